[sv/ssom_pkg.sv]
// Shared types and constants for the sorted set-operation merge block.
package ssom_pkg;

	localparam int KEY_W = 64;
	localparam int CNT_W = 32;

	typedef enum logic [1:0] {
		MODE_INTERSECT     = 2'd0,
		MODE_INTERSECT_ALL = 2'd1,
		MODE_EXCEPT        = 2'd2,
		MODE_EXCEPT_ALL    = 2'd3
	} set_mode_t;

	typedef struct packed {
		logic [KEY_W-1:0] key_value;
		logic             key_is_null;
		logic             from_right;
		logic             end_of_stream;
	} row_t;

	typedef struct packed {
		logic [KEY_W-1:0] group_key;
		logic             group_key_null;
		logic [CNT_W-1:0] copies;
	} result_t;

	// A finished group as handed from the front part to the back part.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             key_null;
		logic [CNT_W-1:0] left_count;
		logic [CNT_W-1:0] right_count;
	} group_t;

	typedef struct packed {
		logic group_open;
		logic group_push;
	} front_status_t;

endpackage

[sv/ssom_front.sv]
// Front part: accepts rows, tracks the open group and closes it into the queue.
module ssom_front import ssom_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  row_t          row,
	output group_t        group_out,
	output front_status_t status
);

	logic             open_q;
	logic [KEY_W-1:0] key_q;
	logic             key_null_q;
	logic [CNT_W-1:0] left_q;
	logic [CNT_W-1:0] right_q;

	logic             same;
	logic [KEY_W-1:0] row_key;

	// A null key is held as zero; two nulls match, a null never matches a value.
	assign row_key = row.key_is_null ? '0 : row.key_value;

	always_comb begin
		if (row.key_is_null || key_null_q) begin
			same = open_q && row.key_is_null && key_null_q;
		end else begin
			same = open_q && (row_key == key_q);
		end
	end

	assign group_out.key         = key_q;
	assign group_out.key_null    = key_null_q;
	assign group_out.left_count  = left_q;
	assign group_out.right_count = right_q;

	assign status.group_open = open_q;
	assign status.group_push = accept && open_q && (row.end_of_stream || !same);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q     <= 1'b0;
			key_q      <= '0;
			key_null_q <= 1'b0;
			left_q     <= '0;
			right_q    <= '0;
		end else if (accept) begin
			if (row.end_of_stream) begin
				open_q     <= 1'b0;
				key_q      <= '0;
				key_null_q <= 1'b0;
				left_q     <= '0;
				right_q    <= '0;
			end else if (same) begin
				if (row.from_right) begin
					right_q <= (right_q == '1) ? right_q : right_q + CNT_W'(1);
				end else begin
					left_q <= (left_q == '1) ? left_q : left_q + CNT_W'(1);
				end
			end else begin
				open_q     <= 1'b1;
				key_q      <= row_key;
				key_null_q <= row.key_is_null;
				left_q     <= row.from_right ? CNT_W'(0) : CNT_W'(1);
				right_q    <= row.from_right ? CNT_W'(1) : CNT_W'(0);
			end
		end
	end

endmodule

[sv/ssom_queue.sv]
// Short queue of finished groups between the front and back parts.
module ssom_queue import ssom_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  group_t wr_data,
	output logic   full,
	input  logic   rd_en,
	output group_t rd_data,
	output logic   empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	group_t          mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[sv/ssom_back.sv]
// Back part: works out the copy count of a finished group and holds the result.
module ssom_back import ssom_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  set_mode_t mode,
	input  logic      q_empty,
	input  group_t    q_data,
	output logic      q_rd,
	output logic      empty,
	input  logic      pop,
	output result_t   result
);

	logic             valid_q;
	result_t          result_q;
	logic [CNT_W-1:0] copies;
	logic             l_nz;
	logic             r_nz;
	logic             l_lt_r;

	assign l_nz   = (q_data.left_count != '0);
	assign r_nz   = (q_data.right_count != '0);
	assign l_lt_r = (q_data.left_count < q_data.right_count);

	always_comb begin
		case (mode)
			MODE_INTERSECT:     copies = (l_nz && r_nz) ? CNT_W'(1) : '0;
			MODE_INTERSECT_ALL: copies = l_lt_r ? q_data.left_count : q_data.right_count;
			MODE_EXCEPT:        copies = (l_nz && !r_nz) ? CNT_W'(1) : '0;
			MODE_EXCEPT_ALL:    copies = l_lt_r ? '0 : q_data.left_count - q_data.right_count;
			default:            copies = '0;
		endcase
	end

	// The output register is refilled in the same cycle that its beat is taken, if the queue holds a group.
	assign q_rd   = !q_empty && (!valid_q || pop);
	assign empty  = !valid_q;
	assign result = result_q;

	always_ff @(posedge clk) begin
		if (q_rd) begin
			result_q.group_key      <= q_data.key;
			result_q.group_key_null <= q_data.key_null;
			result_q.copies         <= copies;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_rd) begin
			valid_q <= (copies != '0);
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

endmodule

[sv/sorted_set_operation_merge_top.sv]
// Top level of the sorted set-operation merge block.
// Rows sorted by key enter through a queue-like port: a beat is taken when push
// is high and full is low. Finished groups leave through a second queue-like
// port: the oldest result sits on result while empty is low and is taken when
// pop is high. Each beat of the input channel is a row or an end marker; a group
// closes when a row with another key or an end marker arrives, and groups whose
// copy count is zero never appear on the output.
// One row is taken every cycle while full is low. The group that a row closes
// is written into the group queue at the edge that takes that row, and passes
// from there through the copy-count stage into the output register once that
// register is empty or being popped. The group queue decouples the two halves,
// so a stalled receiver only blocks the input once the queue and the output
// register are full; full then rises and rows wait upstream.
// The mode register is written through cfg_we and cfg_data and should only be
// changed while no groups are in flight. Reset clears the open group, empties
// the queue and output register, and sets the mode to intersect.
module sorted_set_operation_merge_top import ssom_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  row_t        row,
	output logic        empty,
	input  logic        pop,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_data
);

	set_mode_t     mode_q;
	logic          accept;
	group_t        front_group;
	front_status_t front_st;
	logic          q_full;
	logic          q_empty;
	logic          q_rd;
	group_t        q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_INTERSECT;
		end else if (cfg_we) begin
			mode_q <= set_mode_t'(cfg_data);
		end
	end

	assign full   = q_full;
	assign accept = push && !q_full;

	ssom_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.row       (row),
		.group_out (front_group),
		.status    (front_st)
	);

	ssom_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_st.group_push),
		.wr_data (front_group),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	ssom_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.mode    (mode_q),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

`ifndef SYNTHESIS
	a_no_zero_copies: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.copies != '0)
		else $error("result shown with a zero copy count");

	a_null_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.group_key_null) |-> result.group_key == '0)
		else $error("null group carries a non-zero key");

	a_no_queue_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		front_st.group_push |-> !q_full)
		else $error("finished group pushed into a full queue");

	a_eos_closes_group: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && row.end_of_stream) |=> !front_st.group_open)
		else $error("group still open after an end marker");
`endif

endmodule

[tb/sv/sorted_set_operation_merge_checker.sv]
// Checker that predicts the finished groups of the merge block and compares its results.
module sorted_set_operation_merge_checker import ssom_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  row_t        row,
	input  logic        empty,
	input  logic        pop,
	input  result_t     result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_data,
	output int          fail_count,
	output int          groups_due_count
);
	timeunit 1ns;
	timeprecision 1ps;

	set_mode_t        mode;
	logic             grp_open;
	logic [KEY_W-1:0] grp_key;
	logic             grp_null;
	logic [CNT_W-1:0] left_rows;
	logic [CNT_W-1:0] right_rows;
	result_t          groups_due[$];

	initial fail_count = 0;

	task automatic flag_error(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		fail_count++;
	endtask

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Queues the open group if its copy count under the current mode is nonzero.
	task automatic close_group();
		logic [CNT_W-1:0] n;
		if (!grp_open)
			return;
		case (mode)
			MODE_INTERSECT:
				n = (left_rows != '0 && right_rows != '0) ? CNT_W'(1) : '0;
			MODE_INTERSECT_ALL: n = (left_rows < right_rows) ? left_rows : right_rows;
			MODE_EXCEPT:
				n = (left_rows != '0 && right_rows == '0) ? CNT_W'(1) : '0;
			default:            n = (left_rows < right_rows) ? '0 : left_rows - right_rows;
		endcase
		if (n != '0)
			groups_due.push_back('{grp_key, grp_null, n});
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t          want;
		logic [KEY_W-1:0] k;
		logic             same;
		if (!arst_n) begin
			mode = MODE_INTERSECT;
			grp_open = 1'b0;
			grp_key = '0;
			grp_null = 1'b0;
			left_rows = '0;
			right_rows = '0;
			groups_due.delete();
		end else begin
			if (pop && !empty) begin
				if (groups_due.size() == 0) begin
					flag_error($sformatf("result beat key %h with no group due", result.group_key));
				end else begin
					want = groups_due.pop_front();
					if (result.group_key !== want.group_key)
						flag_error($sformatf("group_key %h, want %h",
							result.group_key, want.group_key));
					if (result.group_key_null !== want.group_key_null)
						flag_error($sformatf("group_key_null %b, want %b",
							result.group_key_null, want.group_key_null));
					if (result.copies !== want.copies)
						flag_error($sformatf("copies %0d, want %0d (key %h)",
							result.copies, want.copies, want.group_key));
				end
			end
			if (push && !full) begin
				if (row.end_of_stream) begin
					close_group();
					grp_open = 1'b0;
					grp_key = '0;
					grp_null = 1'b0;
					left_rows = '0;
					right_rows = '0;
				end else begin
					// A null key is held as zero, yet never matches a real zero key.
					k = row.key_is_null ? '0 : row.key_value;
					same = 1'b0;
					if (grp_open)
						same = (row.key_is_null || grp_null) ? (row.key_is_null && grp_null)
							: (k == grp_key);
					if (same) begin
						if (row.from_right)
							right_rows = bump(right_rows);
						else
							left_rows = bump(left_rows);
					end else begin
						close_group();
						grp_open = 1'b1;
						grp_key = k;
						grp_null = row.key_is_null;
						left_rows = row.from_right ? '0 : CNT_W'(1);
						right_rows = row.from_right ? CNT_W'(1) : '0;
					end
				end
			end
			if (cfg_we)
				mode = set_mode_t'(cfg_data);
		end
		groups_due_count = groups_due.size();
	end

endmodule

[tb/sv/sorted_set_operation_merge_top_tb.sv]
// Testbench top for the sorted set-operation merge block: stimulus, mode changes and verdict.
module sorted_set_operation_merge_top_tb import ssom_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	row_t        row = '0;
	logic        empty;
	logic        pop = 1'b0;
	result_t     result;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_data = '0;
	logic        calm = 1'b0;
	int          fail_count;
	int          groups_due_count;
	int          cycles = 0;

	sorted_set_operation_merge_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.row      (row),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	sorted_set_operation_merge_checker merge_chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.row              (row),
		.empty            (empty),
		.pop              (pop),
		.result           (result),
		.cfg_we           (cfg_we),
		.cfg_data         (cfg_data),
		.fail_count       (fail_count),
		.groups_due_count (groups_due_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// The receiver stalls at random, except during the calm phase.
	always @(posedge clk) begin
		if (arst_n)
			pop <= calm || ($urandom_range(99) >= 34);
	end

	function automatic row_t row_of(input logic [KEY_W-1:0] k, input logic nul,
		input logic rgt, input logic eos);
		return '{k, nul, rgt, eos};
	endfunction

	// Offers one beat and returns at the edge that takes it; full is looked at mid-cycle.
	task automatic send_row(input row_t r);
		logic taken;
		while (!calm && $urandom_range(99) < 34) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		row <= r;
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
	endtask

	// Lets every due group come out, then gives the pipeline time to empty.
	task automatic settle();
		push <= 1'b0;
		repeat (4) @(posedge clk);
		while (groups_due_count != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_mode(input set_mode_t m);
		cfg_we <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int               sent;
		int               pick;
		int               lean;
		logic [KEY_W-1:0] key;
		logic             nul;
		logic             rgt;
		sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// An end marker with nothing open, then null and zero keys kept apart.
		write_mode(MODE_EXCEPT_ALL);
		send_row(row_of('1, 1'b1, 1'b1, 1'b1));
		send_row(row_of('0, 1'b0, 1'b0, 1'b0));
		send_row(row_of('0, 1'b0, 1'b0, 1'b0));
		send_row(row_of('0, 1'b0, 1'b1, 1'b0));
		send_row(row_of('1, 1'b1, 1'b0, 1'b0));
		send_row(row_of(64'd5, 1'b1, 1'b1, 1'b0));
		send_row(row_of('0, 1'b0, 1'b0, 1'b0));
		send_row(row_of(64'h0123_4567_89ab_cdef, 1'b0, 1'b1, 1'b1));
		settle();
		write_mode(MODE_INTERSECT);
		send_row(row_of('1, 1'b0, 1'b1, 1'b0));
		send_row(row_of('1, 1'b0, 1'b0, 1'b0));
		send_row(row_of('1, 1'b0, 1'b0, 1'b0));
		send_row(row_of(64'hffff_ffff_ffff_fffe, 1'b0, 1'b1, 1'b0));
		send_row(row_of('0, 1'b0, 1'b0, 1'b1));
		settle();
		write_mode(MODE_INTERSECT_ALL);
		send_row(row_of(64'd7, 1'b0, 1'b0, 1'b0));
		send_row(row_of(64'd7, 1'b0, 1'b0, 1'b0));
		send_row(row_of(64'd7, 1'b0, 1'b0, 1'b0));
		send_row(row_of(64'd7, 1'b0, 1'b1, 1'b0));
		send_row(row_of(64'd7, 1'b0, 1'b1, 1'b0));
		send_row(row_of('0, 1'b1, 1'b0, 1'b0));
		send_row(row_of('0, 1'b0, 1'b0, 1'b1));
		settle();
		write_mode(MODE_EXCEPT);
		send_row(row_of(64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0));
		send_row(row_of(64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0));
		send_row(row_of(64'h8000_0000_0000_0001, 1'b0, 1'b1, 1'b0));
		send_row(row_of(64'h5555_aaaa_5555_aaaa, 1'b1, 1'b1, 1'b0));
		send_row(row_of('0, 1'b0, 1'b0, 1'b1));

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			write_mode(ph < 4 ? set_mode_t'(ph) : set_mode_t'($urandom_range(3)));
			calm <= (ph == 5);
			while (sent < (ph + 1) * 120) begin
				pick = $urandom_range(99);
				if (pick < 85) begin
					// A run of rows sharing one key, leaning to one side or mixed.
					case ($urandom_range(9))
						0:       key = '0;
						1:       key = '1;
						2:       key = 64'($urandom_range(3));
						default: key = {$urandom(), $urandom()};
					endcase
					nul = ($urandom_range(7) == 0);
					lean = $urandom_range(2);
					for (int i = $urandom_range(1, 6); i > 0; i--) begin
						case (lean)
							0:       rgt = ($urandom_range(3) == 0);
							1:       rgt = ($urandom_range(3) != 0);
							default: rgt = 1'($urandom_range(1));
						endcase
						send_row(row_of(nul ? {$urandom(), $urandom()} : key, nul, rgt, 1'b0));
						sent++;
					end
					if ($urandom_range(9) == 0) begin
						send_row(row_of({$urandom(), $urandom()}, 1'($urandom_range(1)),
							1'($urandom_range(1)), 1'b1));
						sent++;
					end
				end else if (pick < 95) begin
					send_row(row_t'({$urandom(), $urandom(), 3'($urandom_range(7))}));
					sent++;
				end else begin
					// Two end markers in a row: the second finds no open group.
					repeat (2) begin
						send_row(row_of({$urandom(), $urandom()}, 1'($urandom_range(1)),
							1'($urandom_range(1)), 1'b1));
						sent++;
					end
				end
			end
		end
		calm <= 1'b0;
		send_row(row_of('0, 1'b0, 1'b0, 1'b1));
		settle();
		if (fail_count == 0 && groups_due_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
